FILE: hdl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants for the ticket queue with cancel.
// ----------------------------------------------------------------------------
package tfc_pkg;

	// Queue size and ticket width.
	localparam int QUEUE_DEPTH = 16;
	localparam int TICKET_BITS = 16;
	localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
	localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

	typedef logic [TICKET_BITS-1:0] ticket_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [IDX_BITS-1:0]    idx_t;

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_SERVE  = 2'd1,
		OP_LIST   = 2'd2,
		OP_CANCEL = 2'd3
	} opcode_t;

	// Result status codes.
	localparam logic [2:0] STAT_ADDED     = 3'd0;
	localparam logic [2:0] STAT_SERVED    = 3'd1;
	localparam logic [2:0] STAT_CANCELLED = 3'd2;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
	localparam logic [2:0] STAT_EMPTY     = 3'd4;
	localparam logic [2:0] STAT_LISTED    = 3'd5;
	localparam logic [2:0] STAT_FULL      = 3'd6;

	// Command broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_ADD    = 3'd1,
		CELL_SHIFT  = 3'd2,
		CELL_ROTATE = 3'd3,
		CELL_CANCEL = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		ticket_t  new_ticket;
		ticket_t  key;
		count_t   count;
	} cell_ctrl_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

endpackage

FILE: hdl/tfc_cell.sv
// ----------------------------------------------------------------------------
// tfc_cell
// One slot of the ticket chain. Holds one ticket and moves it toward the head
// on serve, cancel and list rotation.
// ----------------------------------------------------------------------------
module tfc_cell (
	input  logic                clk,
	input  tfc_pkg::cell_ctrl_t ctrl,
	input  tfc_pkg::idx_t       idx,
	input  tfc_pkg::ticket_t    data_next,
	input  tfc_pkg::ticket_t    head,
	input  logic                hit_in,
	output tfc_pkg::ticket_t    data,
	output logic                hit_out
);
	import tfc_pkg::*;

	ticket_t data_q;
	count_t  idx_ext;
	logic    occupied;
	logic    is_free;
	logic    is_tail;
	logic    match_here;

	// Position of this cell relative to the fill level.
	assign idx_ext    = count_t'(idx);
	assign occupied   = idx_ext < ctrl.count;
	assign is_free    = idx_ext == ctrl.count;
	assign is_tail    = (idx_ext + count_t'(1)) == ctrl.count;
	assign match_here = occupied && (data_q == ctrl.key);

	// The first match nearest the head propagates down the chain.
	assign hit_out = hit_in || match_here;

	// Slot update.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_ADD: begin
				if (is_free) begin
					data_q <= ctrl.new_ticket;
				end
			end
			CELL_SHIFT: begin
				data_q <= data_next;
			end
			CELL_ROTATE: begin
				if (is_tail) begin
					data_q <= head;
				end else begin
					data_q <= data_next;
				end
			end
			CELL_CANCEL: begin
				if (hit_out) begin
					data_q <= data_next;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

FILE: hdl/ticket_fifo_with_cancel.sv
// ----------------------------------------------------------------------------
// ticket_fifo_with_cancel
// Ticket queue in arrival order with add, serve, list and cancel by number.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The receiver cannot
// hold results off: each result is on the ports for one cycle with strobe
// high. Add, serve, cancel and a list of an empty queue give their single
// result on the cycle after the transfer, so a new command may follow every
// cycle. Listing n waiting tickets rotates the cell chain one step per cycle,
// giving one result per cycle once the block has entered its list state; busy
// stays high until the last ticket has been rotated out, and the next command
// is taken only after busy falls.
module ticket_fifo_with_cancel (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          opcode,
	input  logic [tfc_pkg::TICKET_BITS-1:0]     cancel_number,
	output logic                                strobe,
	output logic [2:0]                          status,
	output logic [tfc_pkg::TICKET_BITS-1:0]     ticket,
	output logic                                last
);
	import tfc_pkg::*;

	state_t     state_q;
	count_t     count_q;
	count_t     left_q;
	ticket_t    next_ticket_q;
	logic       strobe_q;
	logic [2:0] status_q;
	ticket_t    ticket_q;
	logic       last_q;

	cell_ctrl_t ctrl;
	ticket_t    cell_data [QUEUE_DEPTH];
	logic       cell_hit  [QUEUE_DEPTH];
	logic       accept;
	logic       full;
	logic       empty;
	logic       found;

	assign busy   = (state_q == S_LIST);
	assign accept = start && !busy;
	assign full   = (count_q == count_t'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign found  = cell_hit[QUEUE_DEPTH-1];

	// Command broadcast to the cell chain.
	always_comb begin
		ctrl.new_ticket = next_ticket_q;
		ctrl.key        = cancel_number;
		ctrl.count      = count_q;
		ctrl.op         = CELL_HOLD;
		if (busy) begin
			ctrl.op = CELL_ROTATE;
		end else if (accept) begin
			case (opcode)
				OP_ADD:    ctrl.op = full ? CELL_HOLD : CELL_ADD;
				OP_SERVE:  ctrl.op = empty ? CELL_HOLD : CELL_SHIFT;
				OP_CANCEL: ctrl.op = CELL_CANCEL;
				default:   ctrl.op = CELL_HOLD;
			endcase
		end
	end

	// Chain of ticket cells, head at index zero.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		ticket_t nb_data;
		logic    nb_hit;
		if (i == QUEUE_DEPTH - 1) begin : g_end
			assign nb_data = cell_data[i];
		end else begin : g_mid
			assign nb_data = cell_data[i+1];
		end
		if (i == 0) begin : g_head
			assign nb_hit = 1'b0;
		end else begin : g_body
			assign nb_hit = cell_hit[i-1];
		end
		tfc_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (idx_t'(i)),
			.data_next (nb_data),
			.head      (cell_data[0]),
			.hit_in    (nb_hit),
			.data      (cell_data[i]),
			.hit_out   (cell_hit[i])
		);
	end

	// Control state: fill level, ticket counter and list sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			left_q        <= '0;
			next_ticket_q <= ticket_t'(1);
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_LIST: begin
					strobe_q <= 1'b1;
					left_q   <= left_q - count_t'(1);
					if (left_q == count_t'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_ADD: begin
								strobe_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + count_t'(1);
									next_ticket_q <= (&next_ticket_q) ? ticket_t'(1)
										: next_ticket_q + ticket_t'(1);
								end
							end
							OP_SERVE: begin
								strobe_q <= 1'b1;
								if (!empty) begin
									count_q <= count_q - count_t'(1);
								end
							end
							OP_LIST: begin
								if (empty) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_LIST;
									left_q  <= count_q;
								end
							end
							default: begin
								strobe_q <= 1'b1;
								if (found) begin
									count_q <= count_q - count_t'(1);
								end
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (busy) begin
			status_q <= STAT_LISTED;
			ticket_q <= cell_data[0];
			last_q   <= (left_q == count_t'(1));
		end else if (accept) begin
			last_q <= 1'b1;
			case (opcode)
				OP_ADD: begin
					status_q <= full ? STAT_FULL : STAT_ADDED;
					ticket_q <= full ? '0 : next_ticket_q;
				end
				OP_SERVE: begin
					status_q <= empty ? STAT_EMPTY : STAT_SERVED;
					ticket_q <= empty ? '0 : cell_data[0];
				end
				OP_LIST: begin
					status_q <= STAT_EMPTY;
					ticket_q <= '0;
				end
				default: begin
					status_q <= found ? STAT_CANCELLED : STAT_NOT_FOUND;
					ticket_q <= cancel_number;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign ticket = ticket_q;
	assign last   = last_q;

endmodule

FILE: hdl/tfc_checker.sv
// ----------------------------------------------------------------------------
// tfc_checker
// Port-level checks on the ticket queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tfc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic [1:0]                      opcode,
	input logic [tfc_pkg::TICKET_BITS-1:0] cancel_number,
	input logic                            strobe,
	input logic [2:0]                      status,
	input logic [tfc_pkg::TICKET_BITS-1:0] ticket,
	input logic                            last
);
	import tfc_pkg::*;

	// A transfer other than a list gives exactly one final result next cycle.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode != OP_LIST) |=> (strobe && last))
		else $error("single-result command did not finish in one cycle");

	// Every accepted command shows a result or keeps the block busy.
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (strobe || busy))
		else $error("accepted command produced no activity");

	// A list result that is not the last is followed by another result.
	a_list_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("list output broke off before the last entry");

	// Only listed entries may be non-final results.
	a_list_status: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> (status == STAT_LISTED))
		else $error("non-final result is not a listed entry");

	// Empty and full results carry no ticket.
	a_zero_ticket: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status == STAT_EMPTY || status == STAT_FULL)) |-> (ticket == '0))
		else $error("empty or full result carries a ticket");

endmodule

bind ticket_fifo_with_cancel tfc_checker u_tfc_checker (.*);
